[rtl/utf8d_pkg.sv]
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types and constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned CpWidth    = 26;
  localparam int unsigned LenWidth   = 3;
  localparam int unsigned LeadWidth  = 7;
  localparam int unsigned ContWidth  = 6;
  localparam int unsigned QueueDepth = 2;

  // Sequence length codes; zero marks a byte that cannot start a sequence.
  localparam logic [LenWidth-1:0] LenBad = 3'd0;
  localparam logic [LenWidth-1:0] Len1   = 3'd1;
  localparam logic [LenWidth-1:0] Len2   = 3'd2;
  localparam logic [LenWidth-1:0] Len3   = 3'd3;
  localparam logic [LenWidth-1:0] Len4   = 3'd4;
  localparam logic [LenWidth-1:0] Len5   = 3'd5;

  // One classified byte as it waits in the queue.
  typedef struct packed {
    logic [LenWidth-1:0]  lead_len;
    logic [LeadWidth-1:0] lead_bits;
    logic [ContWidth-1:0] cont_bits;
    logic                 eot;
  } item_t;

  // One decoded result.
  typedef struct packed {
    logic [CpWidth-1:0]  code_point;
    logic [LenWidth-1:0] seq_length;
    logic                bad_lead;
    logic                truncated;
  } result_t;

endpackage

[rtl/utf8_stream_decoder_top.sv]
// ----------------------------------------------------------------------------
// Path: an accepted byte is written into the queue; the back end then takes it
//   and loads the result it completes (or flags) into the output register.
// Throughput: one byte per cycle while the queue is not full; the two-entry
//   queue absorbs output stalls.
// Reset: rst_ni clears the sequence state, queue and output valid at once.
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top
// UTF-8 byte stream to code point decoder with a decoupled front and back.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_top #(
  parameter int unsigned QueueDepth = utf8d_pkg::QueueDepth
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // byte channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [utf8d_pkg::ByteWidth-1:0] in_byte_i,
  input  logic                            end_of_text_i,
  // code point channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [utf8d_pkg::CpWidth-1:0]   code_point_o,
  output logic [utf8d_pkg::LenWidth-1:0]  seq_length_o,
  output logic                            bad_lead_o,
  output logic                            truncated_o
);

  // Front to queue.
  logic             q_push;
  logic             q_full;
  utf8d_pkg::item_t q_in_item;

  // Queue to back.
  logic             q_valid;
  logic             q_pop;
  utf8d_pkg::item_t q_out_item;

  utf8d_pkg::result_t res;

  // Classify each byte as it is accepted; the lead length and masked lead
  // bits are computed regardless of sequence state, the back end decides use.
  utf8d_front u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_byte_i     (in_byte_i),
    .end_of_text_i (end_of_text_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_item_o      (q_in_item)
  );

  // Hold classified bytes so input transactions continue while a result
  // waits to be taken.
  utf8d_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (q_in_item),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .pop_i       (q_pop),
    .pop_item_o  (q_out_item)
  );

  // Advance the sequence state one byte per cycle whenever the output
  // register is free or being drained; emit on completion, bad lead or
  // text end in mid-sequence.
  utf8d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_item_i    (q_out_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (res)
  );

  assign code_point_o = res.code_point;
  assign seq_length_o = res.seq_length;
  assign bad_lead_o   = res.bad_lead;
  assign truncated_o  = res.truncated;

endmodule

[rtl/utf8d_front.sv]
// ----------------------------------------------------------------------------
// utf8d_front
// Accepts raw bytes and classifies each as a potential lead byte.
// ----------------------------------------------------------------------------
module utf8d_front (
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [utf8d_pkg::ByteWidth-1:0] in_byte_i,
  input  logic                            end_of_text_i,
  input  logic                            q_full_i,
  output logic                            q_push_o,
  output utf8d_pkg::item_t                q_item_o
);

  logic [utf8d_pkg::LenWidth-1:0]  lead_len;
  logic [utf8d_pkg::LeadWidth-1:0] lead_bits;

  always_comb begin
    lead_len  = utf8d_pkg::LenBad;
    lead_bits = '0;
    if (!in_byte_i[7]) begin
      lead_len  = utf8d_pkg::Len1;
      lead_bits = in_byte_i[6:0];
    end else if (in_byte_i[7:5] == 3'b110) begin
      lead_len  = utf8d_pkg::Len2;
      lead_bits = {2'b00, in_byte_i[4:0]};
    end else if (in_byte_i[7:4] == 4'b1110) begin
      lead_len  = utf8d_pkg::Len3;
      lead_bits = {3'b000, in_byte_i[3:0]};
    end else if (in_byte_i[7:3] == 5'b11110) begin
      lead_len  = utf8d_pkg::Len4;
      lead_bits = {4'b0000, in_byte_i[2:0]};
    end else if (in_byte_i[7:2] == 6'b111110) begin
      lead_len  = utf8d_pkg::Len5;
      lead_bits = {5'b00000, in_byte_i[1:0]};
    end
  end

  assign in_ready_o         = !q_full_i;
  assign q_push_o           = in_valid_i && !q_full_i;
  assign q_item_o.lead_len  = lead_len;
  assign q_item_o.lead_bits = lead_bits;
  assign q_item_o.cont_bits = in_byte_i[utf8d_pkg::ContWidth-1:0];
  assign q_item_o.eot       = end_of_text_i;

endmodule

[rtl/utf8d_queue.sv]
// ----------------------------------------------------------------------------
// utf8d_queue
// Short FIFO of classified bytes between front and back.
// ----------------------------------------------------------------------------
module utf8d_queue #(
  parameter int unsigned Depth = utf8d_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  utf8d_pkg::item_t push_item_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output utf8d_pkg::item_t pop_item_o
);

  localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntWidth = $clog2(Depth + 1);
  localparam logic [PtrWidth-1:0] PtrLast = PtrWidth'(Depth - 1);
  localparam logic [CntWidth-1:0] CntFull = CntWidth'(Depth);

  utf8d_pkg::item_t    mem_q [Depth];
  logic [PtrWidth-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                do_pop;

  assign full_o     = (cnt_q == CntFull);
  assign valid_o    = (cnt_q != '0);
  assign do_pop     = pop_i && valid_o;
  assign pop_item_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

[rtl/utf8d_back.sv]
// ----------------------------------------------------------------------------
// utf8d_back
// Sequence state, shift-and-OR accumulation and the output register.
// ----------------------------------------------------------------------------
module utf8d_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  output logic              q_pop_o,
  input  utf8d_pkg::item_t  q_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output utf8d_pkg::result_t out_res_o
);

  localparam int unsigned CpW  = utf8d_pkg::CpWidth;
  localparam int unsigned CntW = utf8d_pkg::ContWidth;

  logic [CpW-1:0]                 partial_q, partial_d;
  logic [utf8d_pkg::LenWidth-1:0] rem_q, rem_d;
  logic [utf8d_pkg::LenWidth-1:0] cur_q, cur_d;
  logic                           out_valid_q, out_valid_d;
  utf8d_pkg::result_t             res_q, res_d;
  logic                           take;
  logic                           emit;

  assign take    = q_valid_i && (!out_valid_q || out_ready_i);
  assign q_pop_o = take;

  always_comb begin
    partial_d   = partial_q;
    rem_d       = rem_q;
    cur_d       = cur_q;
    res_d       = res_q;
    emit        = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    if (take) begin
      if (rem_q == '0) begin
        if (q_item_i.lead_len == utf8d_pkg::LenBad) begin
          emit  = 1'b1;
          res_d = '{code_point: '0, seq_length: utf8d_pkg::Len1,
                    bad_lead: 1'b1, truncated: 1'b0};
        end else if (q_item_i.lead_len == utf8d_pkg::Len1) begin
          emit  = 1'b1;
          res_d = '{code_point: CpW'(q_item_i.lead_bits), seq_length: utf8d_pkg::Len1,
                    bad_lead: 1'b0, truncated: 1'b0};
        end else if (q_item_i.eot) begin
          // Multi-byte lead that is also the last byte of the text.
          emit  = 1'b1;
          res_d = '{code_point: CpW'(q_item_i.lead_bits), seq_length: q_item_i.lead_len,
                    bad_lead: 1'b0, truncated: 1'b1};
        end else begin
          partial_d = CpW'(q_item_i.lead_bits);
          cur_d     = q_item_i.lead_len;
          rem_d     = q_item_i.lead_len - 1'b1;
        end
      end else begin
        partial_d = {partial_q[CpW-CntW-1:0], q_item_i.cont_bits};
        rem_d     = rem_q - 1'b1;
        if (rem_d == '0 || q_item_i.eot) begin
          emit  = 1'b1;
          res_d = '{code_point: partial_d, seq_length: cur_q,
                    bad_lead: 1'b0, truncated: (rem_d != '0)};
        end
      end
      if (emit) begin
        partial_d   = '0;
        rem_d       = '0;
        cur_d       = '0;
        out_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q   <= '0;
      rem_q       <= '0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      partial_q   <= partial_d;
      rem_q       <= rem_d;
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && emit) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q.bad_lead && res_q.truncated))
    else $error("bad_lead and truncated both set");

  a_bad_lead_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.bad_lead |-> (res_q.code_point == '0) &&
                                      (res_q.seq_length == utf8d_pkg::Len1))
    else $error("bad lead result not zero with length one");

  a_trunc_multibyte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.truncated |-> (res_q.seq_length != utf8d_pkg::Len1) &&
                                       (res_q.seq_length != utf8d_pkg::LenBad))
    else $error("truncated result on a single byte sequence");

  a_rem_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q != '0 |-> rem_q < cur_q)
    else $error("remaining count not below sequence length");

endmodule

[tb/sv/utf8_stream_decoder_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top_tb
// Self-checking bench for the UTF-8 stream decoder. Bytes go in over a
// valid/ready channel; a bit-exact decoder model inside the bench predicts
// every code point, and a monitor compares each transaction on the output
// channel field by field. Directed cases come first, then random streams of
// well-formed sequences, truncated text and stray bytes.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_top_tb;

  logic                                clk_i;
  logic                                rst_ni    = 1'b0;
  logic                                in_valid  = 1'b0;
  logic [utf8d_pkg::ByteWidth-1:0]     in_byte   = '0;
  logic                                in_eot    = 1'b0;
  logic                                out_ready = 1'b0;

  logic                                in_ready_o;
  logic                                out_valid_o;
  logic [utf8d_pkg::CpWidth-1:0]       code_point_o;
  logic [utf8d_pkg::LenWidth-1:0]      seq_length_o;
  logic                                bad_lead_o;
  logic                                truncated_o;

  // Decoder state mirrored by the bench.
  logic [utf8d_pkg::CpWidth-1:0]  acc_value = '0;
  logic [utf8d_pkg::LenWidth-1:0] cont_left = '0;
  logic [utf8d_pkg::LenWidth-1:0] open_len  = '0;

  // Code points predicted but not yet seen on the output.
  utf8d_pkg::result_t pending_cps[$];

  // Idling controls for the sender and the receiver.
  bit src_idle_en  = 1'b0;
  bit sink_stall_en = 1'b0;

  int errors      = 0;
  int bytes_sent  = 0;
  int cps_checked = 0;
  int bad_seen    = 0;
  int trunc_seen  = 0;

  utf8_stream_decoder_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .in_byte_i     (in_byte),
    .end_of_text_i (in_eot),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .code_point_o  (code_point_o),
    .seq_length_o  (seq_length_o),
    .bad_lead_o    (bad_lead_o),
    .truncated_o   (truncated_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Advance the mirrored decoder by one accepted byte and queue the code point
  // it produces, if any.
  task automatic decode_byte(input logic [utf8d_pkg::ByteWidth-1:0] b, input logic eot);
    utf8d_pkg::result_t             r;
    logic [utf8d_pkg::LenWidth-1:0] len;
    logic [utf8d_pkg::CpWidth-1:0]  payload;
    logic                           done;
    r       = '0;
    done    = 1'b0;
    payload = '0;
    if (cont_left == '0) begin
      // Classify the lead byte and keep only its payload bits.
      casez (b)
        8'b0???????: begin
          len = utf8d_pkg::Len1; payload = utf8d_pkg::CpWidth'(b & 8'h7F);
        end
        8'b110?????: begin
          len = utf8d_pkg::Len2; payload = utf8d_pkg::CpWidth'(b & 8'h1F);
        end
        8'b1110????: begin
          len = utf8d_pkg::Len3; payload = utf8d_pkg::CpWidth'(b & 8'h0F);
        end
        8'b11110???: begin
          len = utf8d_pkg::Len4; payload = utf8d_pkg::CpWidth'(b & 8'h07);
        end
        8'b111110??: begin
          len = utf8d_pkg::Len5; payload = utf8d_pkg::CpWidth'(b & 8'h03);
        end
        default:     begin len = utf8d_pkg::LenBad; end
      endcase
      if (len == utf8d_pkg::LenBad) begin
        // Stray byte where a lead belongs: flag it, stay idle.
        r.seq_length = utf8d_pkg::Len1;
        r.bad_lead   = 1'b1;
        done         = 1'b1;
      end else if (len == utf8d_pkg::Len1) begin
        r.code_point = payload;
        r.seq_length = utf8d_pkg::Len1;
        done         = 1'b1;
      end else begin
        acc_value = payload;
        open_len  = len;
        cont_left = len - 3'd1;
      end
    end else begin
      // Any byte counts as a continuation; only its low six bits matter.
      acc_value = {acc_value[utf8d_pkg::CpWidth-utf8d_pkg::ContWidth-1:0],
                   b[utf8d_pkg::ContWidth-1:0]};
      cont_left = cont_left - 3'd1;
      if (cont_left == '0) begin
        r.code_point = acc_value;
        r.seq_length = open_len;
        done         = 1'b1;
        acc_value    = '0;
        open_len     = '0;
      end
    end
    if (!done && eot) begin
      // Text ended inside a sequence: emit what has built up, unshifted.
      r.code_point = acc_value;
      r.seq_length = open_len;
      r.truncated  = 1'b1;
      done         = 1'b1;
      acc_value    = '0;
      cont_left    = '0;
      open_len     = '0;
    end
    if (done) pending_cps.push_back(r);
  endtask

  // Offer one byte, hold it until the decoder takes it, then predict.
  // Returns right after the accepting edge with valid still high.
  task automatic send_byte(input logic [utf8d_pkg::ByteWidth-1:0] b, input logic eot);
    int gap;
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_eot   <= eot;
    do @(posedge clk_i); while (!in_ready_o);
    decode_byte(b, eot);
    bytes_sent++;
  endtask

  // Drop valid and hold off until every predicted code point has come out.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending_cps.size() != 0);
  endtask

  task automatic report_mismatch(input string field, input int got, input int want);
    errors++;
    $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $realtime, field, got, want);
  endtask

  // Receiver: stall in random bursts while enabled.
  initial begin
    int stall_left;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (sink_stall_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 6);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Check every output transaction against the oldest prediction.
  always @(posedge clk_i) begin
    utf8d_pkg::result_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (pending_cps.size() == 0) begin
        report_mismatch("unexpected code_point", int'(code_point_o), 0);
      end else begin
        want = pending_cps.pop_front();
        cps_checked++;
        if (bad_lead_o) bad_seen++;
        if (truncated_o) trunc_seen++;
        if (code_point_o !== want.code_point)
          report_mismatch("code_point", int'(code_point_o), int'(want.code_point));
        if (seq_length_o !== want.seq_length)
          report_mismatch("seq_length", int'(seq_length_o), int'(want.seq_length));
        if (bad_lead_o !== want.bad_lead)
          report_mismatch("bad_lead", int'(bad_lead_o), int'(want.bad_lead));
        if (truncated_o !== want.truncated)
          report_mismatch("truncated", int'(truncated_o), int'(want.truncated));
      end
    end
  end

  // ASCII extremes and one sequence each of two, three and four bytes.
  task automatic test_sequence_lengths();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);      // end of text on a complete byte is no truncation
    send_byte(8'hC0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
  endtask

  // Bytes that cannot lead, at both ends of each illegal range.
  task automatic test_bad_leads();
    send_byte(8'h80, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hFC, 1'b0);
    send_byte(8'hFF, 1'b1);      // flagged as bad lead, never as truncated
  endtask

  // Text that stops on a lead byte and on a middle continuation.
  task automatic test_truncated_text();
    send_byte(8'hC3, 1'b1);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b1);
  endtask

  // Continuations with wrong top bits still feed their low six bits.
  task automatic test_loose_continuations();
    send_byte(8'hDF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFB, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h3F, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'h7F, 1'b0);      // five-byte maximum, all payload bits set
  endtask

  // Mostly well-formed sequences with random payloads; some stray bytes,
  // loose continuations and early text ends mixed in.
  task automatic test_random_stream(input int n_bytes);
    int                              stop_at;
    int                              len;
    logic [utf8d_pkg::ByteWidth-1:0] b;
    logic                            eot;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 5) == 0) begin
        b   = 8'($urandom_range(0, 255));
        eot = ($urandom_range(0, 7) == 0);
        send_byte(b, eot);
      end else begin
        len = $urandom_range(1, 5);
        case (len)
          1: b = 8'($urandom_range(0, 127));
          2: b = 8'hC0 | 8'($urandom_range(0, 31));
          3: b = 8'hE0 | 8'($urandom_range(0, 15));
          4: b = 8'hF0 | 8'($urandom_range(0, 7));
          default: b = 8'hF8 | 8'($urandom_range(0, 3));
        endcase
        for (int i = 0; i < len; i++) begin
          if (i != 0) begin
            if ($urandom_range(0, 9) == 0) b = 8'($urandom_range(0, 255));
            else b = 8'h80 | 8'($urandom_range(0, 63));
          end
          eot = ($urandom_range(0, 19) == 0);
          send_byte(b, eot);
          // Abandon the rest of the sequence once the text has ended.
          if (eot) break;
        end
      end
    end
  endtask

  // Pause the sender mid-stream until the output side has fully drained.
  task automatic test_drain_pause();
    test_random_stream(20);
    wait_quiet();
    test_random_stream(20);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_sequence_lengths();
    test_bad_leads();
    test_truncated_text();
    test_loose_continuations();

    src_idle_en   = 1'b1;
    sink_stall_en = 1'b1;
    test_random_stream(180);
    test_drain_pause();
    test_random_stream(180);

    // Final stretch at full rate on both sides.
    src_idle_en   = 1'b0;
    sink_stall_en = 1'b0;
    test_random_stream(100);

    wait_quiet();
    repeat (8) @(posedge clk_i);

    $display("Sent %0d bytes; checked %0d code points, %0d bad leads, %0d truncated.",
             bytes_sent, cps_checked, bad_seen, trunc_seen);
    if (errors == 0) begin
      $display("utf8_stream_decoder_top_tb: done, clean");
    end else begin
      $display("utf8_stream_decoder_top_tb: done, errors");
    end
    $finish;
  end

  // Watchdog: a stuck handshake ends the run here.
  initial begin
    #400000;
    $display("utf8_stream_decoder_top_tb: done, errors");
    $finish;
  end

endmodule

[filelist.f]
rtl/utf8d_pkg.sv
rtl/utf8d_front.sv
rtl/utf8d_queue.sv
rtl/utf8d_back.sv
rtl/utf8_stream_decoder_top.sv
tb/sv/utf8_stream_decoder_top_tb.sv
